/* design/bvm_pkg.sv */
package bvm_pkg;

  localparam int MemoryBytes = 4096;
  localparam int MemAw = $clog2(MemoryBytes);
  localparam int StackDepth = 16;
  localparam int StackAw = $clog2(StackDepth);
  localparam int KeyCount = 16;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_EXEC = 2'd1;
  localparam logic [1:0] OP_COLL = 2'd2;
  localparam logic [1:0] OP_READ = 2'd3;

  localparam logic [11:0] RESET_START = 12'd512;

  typedef struct packed {
    logic [1:0]  operation;
    logic [11:0] address;
    logic [7:0]  data;
    logic [15:0] keypad;
    logic [7:0]  random_byte;
    logic        collision;
  } request_t;

  typedef struct packed {
    logic [11:0] program_counter;
    logic [7:0]  read_data;
    logic        clear_screen;
    logic        draw_request;
    logic [7:0]  draw_x;
    logic [7:0]  draw_y;
    logic [11:0] sprite_address;
    logic [3:0]  sprite_rows;
    logic        invalid_instruction;
    logic        waiting_for_key;
  } result_t;

  // datapath commands
  typedef struct packed {
    logic        capture;   // latch request
    logic        mem_rd;    // read memory at mem_addr, data next cycle
    logic        mem_wr;
    logic [2:0]  mem_asel;  // address source
    logic [1:0]  mem_dsel;  // write data source
    logic        ins_hi;    // latch instruction high byte
    logic        ins_lo;
    logic        execute;   // single-cycle execute of non-memory instruction
    logic        load_v;    // load V[cnt] from memory data
    logic        cnt_inc;
    logic        cnt_clr;
    logic        coll;
    logic        emit;
  } cmd_t;

  localparam logic [2:0] ASEL_REQ = 3'd0;
  localparam logic [2:0] ASEL_PC = 3'd1;
  localparam logic [2:0] ASEL_PC1 = 3'd2;
  localparam logic [2:0] ASEL_ICNT = 3'd3;

  localparam logic [1:0] DSEL_REQ = 2'd0;
  localparam logic [1:0] DSEL_BCD = 2'd1;
  localparam logic [1:0] DSEL_VCNT = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] ins;
    logic [3:0]  cnt;
  } status_t;

endpackage

/* design/bytecode_vm_execute_unit_core.sv */
// Memory write/read and flag set go from accept straight to emit; instructions fetch two bytes,
// decode, then execute, or write BCD digits, store V0..Vx, or load V0..Vx one byte at a time.
// One request at a time; busy is high while it runs, the one memory port sets the pace.
// Result appears with done for one cycle; the receiver cannot stall.
// Sync reset clears V, I, SP, timers and FSM; sets PC to 512; memory and stack are undefined.
module bytecode_vm_execute_unit_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  bvm_pkg::request_t request,
  output logic              done,
  output bvm_pkg::result_t  result,
  input  logic              cfg_we,
  input  logic [11:0]       cfg_data
);

  bvm_pkg::cmd_t cmd;
  bvm_pkg::status_t status;

  bvm_control u_control (
    .clk(clk), .rst(rst), .start(start), .req(request), .status(status),
    .cmd(cmd), .busy(busy), .done(done)
  );

  bvm_datapath u_datapath (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data), .req(request),
    .cmd(cmd), .status(status), .result(result)
  );

endmodule

/* design/bvm_datapath.sv */
module bvm_datapath (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [11:0]         cfg_data,
  input  bvm_pkg::request_t   req,
  input  bvm_pkg::cmd_t       cmd,
  output bvm_pkg::status_t    status,
  output bvm_pkg::result_t    result
);

  logic [7:0] mem [bvm_pkg::MemoryBytes];
  logic [11:0] stack [bvm_pkg::StackDepth];

  bvm_pkg::request_t rq;
  bvm_pkg::request_t cur;
  logic [15:0] ins;
  logic [3:0] cnt;
  logic [7:0] v [16];
  logic [11:0] index_reg, pc;
  logic [bvm_pkg::StackAw-1:0] sp;
  logic [7:0] delay_reg, sound_reg;
  logic [7:0] mem_q;
  logic [11:0] mem_addr;
  logic [7:0] mem_wdata;
  bvm_pkg::result_t res;

  logic [3:0] x, y, n;
  logic [7:0] kk, vx, vy;
  logic [11:0] nnn;
  logic [7:0] hund, tens, ones;
  logic [7:0] r10;

  // the request is only latched at the accept edge; use the live one then
  assign cur = cmd.capture ? req : rq;

  assign x = ins[11:8];
  assign y = ins[7:4];
  assign n = ins[3:0];
  assign kk = ins[7:0];
  assign nnn = ins[11:0];
  assign vx = v[x];
  assign vy = v[y];

  // BCD digits: hundreds by compare and subtract, tens by multiply and shift; values stay below 256
  always_comb begin
    hund = 8'd0;
    r10 = vx;
    if (r10 >= 8'd200) begin
      hund = 8'd2;
      r10 = r10 - 8'd200;
    end else if (r10 >= 8'd100) begin
      hund = 8'd1;
      r10 = r10 - 8'd100;
    end
    tens = 8'((16'(r10) * 16'd205) >> 11);
    ones = r10 - 8'(tens * 8'd10);
  end

  always_comb begin
    case (cmd.mem_asel)
      bvm_pkg::ASEL_PC:   mem_addr = pc;
      bvm_pkg::ASEL_PC1:  mem_addr = pc + 12'd1;
      bvm_pkg::ASEL_ICNT: mem_addr = index_reg + 12'(cnt);
      default:            mem_addr = cur.address;
    endcase
    case (cmd.mem_dsel)
      bvm_pkg::DSEL_BCD:  mem_wdata = (cnt == 4'd0) ? hund : (cnt == 4'd1) ? tens : ones;
      bvm_pkg::DSEL_VCNT: mem_wdata = v[cnt];
      default:            mem_wdata = cur.data;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      mem[mem_addr[bvm_pkg::MemAw-1:0]] <= mem_wdata;
    end
    if (cmd.mem_rd) begin
      mem_q <= mem[mem_addr[bvm_pkg::MemAw-1:0]];
    end
  end

  function automatic logic key_down(logic [15:0] pad, logic [7:0] k);
    logic r;
    r = 1'b0;
    if (k < 8'(bvm_pkg::KeyCount)) begin
      r = pad[k[3:0]];
    end
    return r;
  endfunction

  logic [11:0] pc2;
  logic key_found;
  logic [3:0] key_idx;
  assign pc2 = pc + 12'd2;

  always_comb begin
    key_found = 1'b0;
    key_idx = 4'd0;
    for (int k = 15; k >= 0; k--) begin
      if (k < bvm_pkg::KeyCount && rq.keypad[k]) begin
        key_found = 1'b1;
        key_idx = 4'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) begin
        v[i] <= 8'd0;
      end
      index_reg <= 12'd0;
      pc <= bvm_pkg::RESET_START;
      sp <= '0;
      delay_reg <= 8'd0;
      sound_reg <= 8'd0;
    end else begin
      if (cfg_we) begin
        pc <= cfg_data;
      end
      if (cmd.coll) begin
        v[15] <= {7'd0, cur.collision};
      end
      if (cmd.ins_lo) begin
        pc <= pc2;
      end
      if (cmd.load_v) begin
        v[cnt] <= mem_q;
      end
      if (cmd.execute) begin
        if (ins == 16'h00ee) begin
          pc <= stack[sp - 1'b1];
          sp <= sp - 1'b1;
        end else if (ins != 16'h00e0) begin
          case (ins[15:12])
            4'h1: pc <= nnn;
            4'h2: begin
              pc <= nnn;
              sp <= sp + 1'b1;
            end
            4'h3: if (vx == kk) pc <= pc + 12'd2;
            4'h4: if (vx != kk) pc <= pc + 12'd2;
            4'h5: if (vx == vy) pc <= pc + 12'd2;
            4'h6: v[x] <= kk;
            4'h7: v[x] <= vx + kk;
            4'h8: begin
              // the result wins over the flag when x is VF
              case (n)
                4'h0: v[x] <= vy;
                4'h1: v[x] <= vx | vy;
                4'h2: v[x] <= vx & vy;
                4'h3: v[x] <= vx ^ vy;
                4'h4: begin
                  if (x != 4'hf) v[15] <= {7'd0, (9'(vx) + 9'(vy)) > 9'h0ff};
                  v[x] <= vx + vy;
                end
                4'h5: begin
                  if (x != 4'hf) v[15] <= {7'd0, vx > vy};
                  v[x] <= vx - vy;
                end
                4'h6: begin
                  if (x != 4'hf) v[15] <= {7'd0, vx[0]};
                  v[x] <= vx >> 1;
                end
                4'h7: begin
                  if (x != 4'hf) v[15] <= {7'd0, vy > vx};
                  v[x] <= vy - vx;
                end
                4'he: begin
                  if (x != 4'hf) v[15] <= {7'd0, vx[7]};
                  v[x] <= vx << 1;
                end
                default: ;
              endcase
            end
            4'h9: if (vx != vy) pc <= pc + 12'd2;
            4'ha: index_reg <= nnn;
            4'hb: pc <= nnn + 12'(v[0]);
            4'hc: v[x] <= rq.random_byte & kk;
            4'he: begin
              if (kk == 8'h9e && key_down(rq.keypad, vx)) pc <= pc + 12'd2;
              if (kk == 8'ha1 && !key_down(rq.keypad, vx)) pc <= pc + 12'd2;
            end
            4'hf: begin
              case (kk)
                8'h07: v[x] <= delay_reg;
                8'h0a: begin
                  if (key_found) v[x] <= {4'd0, key_idx};
                  else pc <= pc - 12'd2;
                end
                8'h15: delay_reg <= vx;
                8'h18: sound_reg <= vx;
                8'h1e: index_reg <= index_reg + 12'(vx);
                8'h29: index_reg <= 12'(vx) * 12'd5;
                default: ;
              endcase
            end
            default: ;
          endcase
        end
      end
    end
  end

  // call pushes the return address; entries are undefined until written
  always_ff @(posedge clk) begin
    if (cmd.execute && ins[15:12] == 4'h2) begin
      stack[sp] <= pc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) rq <= req;
    if (cmd.ins_hi) ins[15:8] <= mem_q;
    if (cmd.ins_lo) ins[7:0] <= mem_q;
    if (cmd.cnt_clr) cnt <= 4'd0;
    else if (cmd.cnt_inc) cnt <= cnt + 4'd1;
  end

  // result fields from current state and decoded instruction
  logic bad;
  always_comb begin
    bad = 1'b0;
    case (ins[15:12])
      4'h0: bad = ins != 16'h00e0 && ins != 16'h00ee;
      4'h8: bad = !(n <= 4'h7 || n == 4'he);
      4'he: bad = kk != 8'h9e && kk != 8'ha1;
      4'hf: bad = !(kk == 8'h07 || kk == 8'h0a || kk == 8'h15 || kk == 8'h18 ||
                    kk == 8'h1e || kk == 8'h29 || kk == 8'h33 || kk == 8'h55 ||
                    kk == 8'h65);
      default: bad = 1'b0;
    endcase
    res = '0;
    res.program_counter = pc;
    if (rq.operation == bvm_pkg::OP_READ) begin
      res.read_data = mem_q;
    end else if (rq.operation == bvm_pkg::OP_EXEC) begin
      res.clear_screen = ins == 16'h00e0;
      res.invalid_instruction = bad;
      if (ins[15:12] == 4'hd) begin
        res.draw_request = 1'b1;
        res.draw_x = vx;
        res.draw_y = vy;
        res.sprite_address = index_reg;
        res.sprite_rows = n;
      end
      res.waiting_for_key = ins[15:12] == 4'hf && kk == 8'h0a && !key_found;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) result <= res;
  end

  assign status.operation = rq.operation;
  assign status.ins = ins;
  assign status.cnt = cnt;

endmodule

/* design/bvm_control.sv */
module bvm_control (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  bvm_pkg::request_t req,
  input  bvm_pkg::status_t  status,
  output bvm_pkg::cmd_t     cmd,
  output logic              busy,
  output logic              done
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_FHI = 4'd2;
  localparam logic [3:0] S_FLO = 4'd3;
  localparam logic [3:0] S_DEC = 4'd4;
  localparam logic [3:0] S_BCD = 4'd5;
  localparam logic [3:0] S_STORE = 4'd6;
  localparam logic [3:0] S_LRD = 4'd7;
  localparam logic [3:0] S_LWB = 4'd8;
  localparam logic [3:0] S_EMIT = 4'd9;

  logic [3:0] state, state_next;
  logic done_next;
  logic [3:0] x;
  logic [7:0] kk;
  assign x = status.ins[11:8];
  assign kk = status.ins[7:0];

  always_comb begin
    cmd = '0;
    state_next = state;
    done_next = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          case (req.operation)
            bvm_pkg::OP_WRITE: begin
              cmd.mem_wr = 1'b1;
              state_next = S_EMIT;
            end
            bvm_pkg::OP_READ: begin
              cmd.mem_rd = 1'b1;
              state_next = S_EMIT;
            end
            bvm_pkg::OP_COLL: begin
              cmd.coll = 1'b1;
              state_next = S_EMIT;
            end
            default: begin
              cmd.mem_rd = 1'b1;
              cmd.mem_asel = bvm_pkg::ASEL_PC;
              state_next = S_FHI;
            end
          endcase
        end
      end
      S_FHI: begin
        cmd.ins_hi = 1'b1;
        cmd.mem_rd = 1'b1;
        cmd.mem_asel = bvm_pkg::ASEL_PC1;
        state_next = S_FLO;
      end
      S_FLO: begin
        // advance pc by two here
        cmd.ins_lo = 1'b1;
        cmd.cnt_clr = 1'b1;
        state_next = S_DEC;
      end
      S_DEC: begin
        if (status.ins[15:12] == 4'hf && kk == 8'h33) begin
          state_next = S_BCD;
        end else if (status.ins[15:12] == 4'hf && kk == 8'h55) begin
          state_next = S_STORE;
        end else if (status.ins[15:12] == 4'hf && kk == 8'h65) begin
          state_next = S_LRD;
        end else begin
          cmd.execute = 1'b1;
          state_next = S_EMIT;
        end
      end
      S_BCD: begin
        cmd.mem_wr = 1'b1;
        cmd.mem_asel = bvm_pkg::ASEL_ICNT;
        cmd.mem_dsel = bvm_pkg::DSEL_BCD;
        cmd.cnt_inc = 1'b1;
        if (status.cnt == 4'd2) state_next = S_EMIT;
      end
      S_STORE: begin
        cmd.mem_wr = 1'b1;
        cmd.mem_asel = bvm_pkg::ASEL_ICNT;
        cmd.mem_dsel = bvm_pkg::DSEL_VCNT;
        cmd.cnt_inc = 1'b1;
        if (status.cnt == x) state_next = S_EMIT;
      end
      S_LRD: begin
        cmd.mem_rd = 1'b1;
        cmd.mem_asel = bvm_pkg::ASEL_ICNT;
        state_next = S_LWB;
      end
      S_LWB: begin
        cmd.load_v = 1'b1;
        cmd.cnt_inc = 1'b1;
        state_next = (status.cnt == x) ? S_EMIT : S_LRD;
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        done_next = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= done_next;
    end
  end

  assign busy = state != S_IDLE;

  a_done_follows_emit: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> done) else $error("done missing after emit");
  a_idle_after_emit: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> state == S_IDLE) else $error("not idle after emit");
  a_capture_only_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |-> !busy) else $error("capture while busy");

endmodule
